// ===== rtl/rmmn_pkg.sv =====
// shared types and constants for the running min/max normalizer
package rmmn_pkg;

    localparam int SENSOR_COUNT_DEF  = 4;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int AXES              = 3;
    localparam int SENSOR_W          = 2;
    localparam int VALUE_W           = 32;
    localparam int RESULT_W          = 17;

    typedef enum logic [0:0] {
        OP_UPDATE    = 1'b0,
        OP_NORMALIZE = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        RANGE_IN    = 2'd0,
        RANGE_BELOW = 2'd1,
        RANGE_ABOVE = 2'd2
    } t_range;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_opcode                    opcode;
        logic [SENSOR_W-1:0]        sensor;
        logic signed [VALUE_W-1:0]  value_x;
        logic signed [VALUE_W-1:0]  value_y;
        logic signed [VALUE_W-1:0]  value_z;
    } t_in_item;

    typedef struct packed {
        logic [RESULT_W-1:0] result_x;
        logic [RESULT_W-1:0] result_y;
        logic [RESULT_W-1:0] result_z;
        t_range              range_x;
        t_range              range_y;
        t_range              range_z;
    } t_out_item;

endpackage

// ===== rtl/running_minmax_normalizer.sv =====
// running min/max tracker and normalizer for several three-axis sensors
//
// Input channel (i_in_valid / o_in_ready / i_in_data): one item carries an
// opcode, a sensor index and three signed axis values. An update item folds
// the values into each axis's running min and max (the first reading on an
// axis seeds both); a normalize item maps each axis to (x-min)/(max-min) with
// FRACTION_BITS fractional bits, clipped to 0..1.0, plus a range flag.
// Output channel (o_out_valid / i_out_ready / o_out_data): exactly one result
// item per input item; update items and unknown sensors give all zeros.
// Each axis is handled in turn: a memory read step, then a compare step.
// An in-range normalize axis then runs a restoring divider that resolves one
// quotient bit per cycle, FRACTION_BITS+1 bits in all, shared by all three axes.
// The input is ready again in the same cycle that o_out_valid rises, and one
// item is worked at a time. A finished result sits in the output register
// while the next item is accepted; if the receiver stalls, the following
// result waits in the last step until that register frees up. Reset marks
// every axis unseen, so it reads as min = max = 0 (the memory itself is not
// cleared), and empties the output register.
module running_minmax_normalizer #(
    parameter int SENSOR_COUNT  = rmmn_pkg::SENSOR_COUNT_DEF,
    parameter int FRACTION_BITS = rmmn_pkg::FRACTION_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rmmn_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rmmn_pkg::t_out_item o_out_data
);

    localparam int AXES  = rmmn_pkg::AXES;
    localparam int CH_N  = AXES * SENSOR_COUNT;
    localparam int CH_W  = $clog2(CH_N);
    localparam int AX_W  = $clog2(AXES);
    localparam int VAL_W = rmmn_pkg::VALUE_W;
    localparam int RES_W = rmmn_pkg::RESULT_W;
    localparam int Q_W   = FRACTION_BITS + 1;
    localparam int CNT_W = $clog2(FRACTION_BITS + 1);

    localparam logic [Q_W-1:0]  QUOT_ONE  = {1'b1, {FRACTION_BITS{1'b0}}};
    localparam logic [AX_W-1:0] LAST_AXIS = AX_W'(AXES - 1);

    rmmn_pkg::t_state    r_state, n_state;
    rmmn_pkg::t_in_item  r_item;
    logic [CH_W-1:0]     r_ch;
    logic [AX_W-1:0]     r_axis;
    logic [CH_N-1:0]     r_first_seen;

    logic signed [VAL_W-1:0] mem_min [CH_N];
    logic signed [VAL_W-1:0] mem_max [CH_N];
    logic signed [VAL_W-1:0] r_min_rd;
    logic signed [VAL_W-1:0] r_max_rd;

    logic [VAL_W:0]      r_rem;
    logic [VAL_W-1:0]    r_den;
    logic [Q_W-1:0]      r_quot;
    logic [CNT_W-1:0]    r_cnt;
    logic [Q_W-1:0]      r_res  [AXES];
    rmmn_pkg::t_range    r_flag [AXES];

    logic                r_out_valid;
    rmmn_pkg::t_out_item r_out;

    logic signed [VAL_W-1:0] x_cur;
    logic signed [VAL_W-1:0] lo;
    logic signed [VAL_W-1:0] hi;
    logic signed [VAL_W-1:0] min_wr;
    logic signed [VAL_W-1:0] max_wr;
    logic                    first;
    logic                    below;
    logic                    above;
    logic                    flat;
    logic [VAL_W:0]          diff;
    logic [VAL_W:0]          span;
    logic                    rem_ge;
    logic [VAL_W:0]          rem_sub;
    logic                    is_upd;
    logic                    in_ok;
    logic                    in_acc;
    logic                    mem_we;
    logic                    div_start;
    logic                    axis_end;
    logic                    out_load;

    assign o_in_ready  = (r_state == rmmn_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // datapath decode
    always_comb begin
        case (r_axis)
            AX_W'(0): x_cur = r_item.value_x;
            AX_W'(1): x_cur = r_item.value_y;
            default:  x_cur = r_item.value_z;
        endcase
        first     = r_first_seen[r_ch];
        lo        = first ? '0 : r_min_rd;
        hi        = first ? '0 : r_max_rd;
        below     = (x_cur < lo);
        above     = (x_cur > hi);
        flat      = (hi == lo);
        diff      = {x_cur[VAL_W-1], x_cur} - {lo[VAL_W-1], lo};
        span      = {hi[VAL_W-1], hi} - {lo[VAL_W-1], lo};
        rem_ge    = (r_rem >= {1'b0, r_den});
        rem_sub   = r_rem - {1'b0, r_den};
        is_upd    = (r_item.opcode == rmmn_pkg::OP_UPDATE);
        min_wr    = (first || below) ? x_cur : lo;
        max_wr    = (first || above) ? x_cur : hi;
        in_ok     = (32'(i_in_data.sensor) < 32'(SENSOR_COUNT));
        in_acc    = (r_state == rmmn_pkg::ST_IDLE) && i_in_valid;
        mem_we    = (r_state == rmmn_pkg::ST_EVAL) && is_upd;
        div_start = (r_state == rmmn_pkg::ST_EVAL) && !is_upd && !below && !above && !flat;
        axis_end  = ((r_state == rmmn_pkg::ST_EVAL) && !div_start)
                 || ((r_state == rmmn_pkg::ST_DIV) && (r_cnt == '0));
        out_load  = (r_state == rmmn_pkg::ST_DONE) && (!r_out_valid || i_out_ready);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rmmn_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = in_ok ? rmmn_pkg::ST_READ : rmmn_pkg::ST_DONE;
                end
            end
            rmmn_pkg::ST_READ: begin
                n_state = rmmn_pkg::ST_EVAL;
            end
            rmmn_pkg::ST_EVAL, rmmn_pkg::ST_DIV: begin
                if (div_start) begin
                    n_state = rmmn_pkg::ST_DIV;
                end else if (axis_end) begin
                    n_state = (r_axis == LAST_AXIS) ? rmmn_pkg::ST_DONE : rmmn_pkg::ST_READ;
                end
            end
            rmmn_pkg::ST_DONE: begin
                if (out_load) begin
                    n_state = rmmn_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rmmn_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= rmmn_pkg::ST_IDLE;
            r_first_seen <= '1;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (mem_we) begin
                r_first_seen[r_ch] <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // min/max storage, registered read at the current channel
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_min[r_ch] <= min_wr;
            mem_max[r_ch] <= max_wr;
        end
        r_min_rd <= mem_min[r_ch];
        r_max_rd <= mem_max[r_ch];
    end

    // item, axis walk and divider
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= i_in_data;
            r_ch   <= CH_W'(4'(i_in_data.sensor) * 4'd3);
            r_axis <= '0;
            for (int a = 0; a < AXES; a++) begin
                r_res[a]  <= '0;
                r_flag[a] <= rmmn_pkg::RANGE_IN;
            end
        end
        if ((r_state == rmmn_pkg::ST_EVAL) && !is_upd) begin
            if (below) begin
                r_flag[r_axis] <= rmmn_pkg::RANGE_BELOW;
            end else if (above) begin
                r_res[r_axis]  <= QUOT_ONE;
                r_flag[r_axis] <= rmmn_pkg::RANGE_ABOVE;
            end
        end
        if (div_start) begin
            r_rem  <= diff;
            r_den  <= span[VAL_W-1:0];
            r_quot <= '0;
            r_cnt  <= CNT_W'(FRACTION_BITS);
        end
        if (r_state == rmmn_pkg::ST_DIV) begin
            // after each step the remainder is below the divisor, so the shift fits
            r_rem  <= rem_ge ? {rem_sub[VAL_W-1:0], 1'b0} : {r_rem[VAL_W-1:0], 1'b0};
            r_quot <= {r_quot[Q_W-2:0], rem_ge};
            r_cnt  <= r_cnt - CNT_W'(1);
            if (r_cnt == '0) begin
                r_res[r_axis] <= {r_quot[Q_W-2:0], rem_ge};
            end
        end
        if (axis_end && (r_axis != LAST_AXIS)) begin
            r_axis <= r_axis + AX_W'(1);
            r_ch   <= r_ch + CH_W'(1);
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.result_x <= RES_W'(r_res[0]);
            r_out.result_y <= RES_W'(r_res[1]);
            r_out.result_z <= RES_W'(r_res[2]);
            r_out.range_x  <= r_flag[0];
            r_out.range_y  <= r_flag[1];
            r_out.range_z  <= r_flag[2];
        end
    end

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rmmn_pkg::ST_DIV) |-> (r_den != '0))
        else $error("divider running on a flat range");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rmmn_pkg::ST_DIV) |-> (r_rem < {r_den, 1'b0}))
        else $error("divider remainder out of bounds");

    a_below_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.range_x == rmmn_pkg::RANGE_BELOW))
            |-> (o_out_data.result_x == '0))
        else $error("below-range axis with nonzero result");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rmmn_pkg::ST_DONE && r_out_valid && !i_out_ready)
            |=> (r_state == rmmn_pkg::ST_DONE))
        else $error("result left the last step while output register was full");

endmodule
